>>> hdl/adcdf_pkg.sv
// shared types, constants and the sample unpack function for the block deframer
`timescale 1ns / 1ps

package adcdf_pkg;

   localparam logic [31:0] MAGIC_WORD   = 32'hDEADBEEF;
   localparam int          HEADER_WORDS = 5;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_BYTES   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_SAMPLES = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SKIP_BLOCKS   = 2'd2;

   localparam logic [15:0] BLOCK_BYTES_RESET   = 16'd512;
   localparam logic [15:0] BLOCK_SAMPLES_RESET = 16'd328;
   localparam logic [15:0] SKIP_BLOCKS_RESET   = 16'd0;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] LAST_SAMPLE_INDEX = 3'd7;

   typedef enum logic [1:0] {
      STATUS_SAMPLE = 2'd0,
      STATUS_MAGIC  = 2'd1,
      STATUS_LENGTH = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      GROUP_FIRST  = 2'd0,
      GROUP_SECOND = 2'd1,
      GROUP_THIRD  = 2'd2
   } group_type;

   typedef struct packed {
      status_type  kind;
      logic [31:0] first_word;
      logic [31:0] second_word;
      logic [31:0] third_word;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [11:0] unpack_sample(input cmd_type cmd, input logic [2:0] idx);
      logic [11:0] result;
      unique case (idx)
         3'd0: result = cmd.first_word[11:0];
         3'd1: result = cmd.first_word[27:16];
         3'd2: result = cmd.second_word[11:0];
         3'd3: result = cmd.second_word[27:16];
         3'd4: result = cmd.third_word[11:0];
         3'd5: result = cmd.third_word[27:16];
         3'd6: result = {cmd.first_word[15:12], cmd.second_word[15:12],
                         cmd.third_word[15:12]};
         3'd7: result = {cmd.first_word[31:28], cmd.second_word[31:28],
                         cmd.third_word[31:28]};
         default: result = '0;
      endcase
      return result;
   endfunction

endpackage

>>> hdl/adc_block_deframe_unpack12.sv
// top level of the block deframer and 12-bit sample unpacker
// path: a header error or the third word of a group is written to a queue entry, then
//   loaded into the result register, which shows its first result beat
// throughput: one word beat per cycle while the four-entry command queue has room;
//   each group of three words yields eight result beats, one per cycle while rsp_ready is high
// reset: synchronous, clears framing counters, halt flag, queue and output; config
//   returns to 512 bytes per block, 328 samples per block, no skipped blocks
`timescale 1ns / 1ps

module adc_block_deframe_unpack12
   import adcdf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [31:0]                req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic signed [11:0]         rsp_sample,
   output logic                       rsp_last
);

   queue_status_type queue_status;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   logic             push;
   logic             pop;

   adcdf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_word     (req_word),
      .queue_status (queue_status),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   adcdf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (queue_status)
   );

   adcdf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_cmd     (head_cmd),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_sample   (rsp_sample),
      .rsp_last     (rsp_last)
   );

endmodule

>>> hdl/adcdf_front.sv
// front end: config registers, block framing, header checks and word grouping
`timescale 1ns / 1ps

module adcdf_front
   import adcdf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [31:0]                req_word,
   input  queue_status_type           queue_status,
   output logic                       push,
   output cmd_type                    push_cmd
);

   logic [15:0] block_bytes_ff, block_samples_ff, skip_blocks_ff;
   logic [15:0] block_bytes_in, block_samples_in, skip_blocks_in;

   logic [13:0] word_in_block_ff, word_in_block_in;
   logic [15:0] blocks_dropped_ff, blocks_dropped_in;
   group_type   group_position_ff, group_position_in;
   logic [31:0] first_word_ff, first_word_in;
   logic [31:0] second_word_ff, second_word_in;
   logic        halted_ff, halted_in;

   logic        accept;
   logic        dropping;
   logic        block_end;
   logic        in_body;
   logic        errored;
   logic [14:0] limit;
   logic [13:0] body;

   assign req_ready = halted_ff | ~queue_status.full;
   assign accept    = req_valid & req_ready & ~halted_ff;
   assign dropping  = blocks_dropped_ff < skip_blocks_ff;
   assign block_end = ({1'b0, word_in_block_ff} + 15'd1) >= {1'b0, block_bytes_ff[15:2]};
   assign limit     = {2'b00, block_samples_ff[15:3]} +
                      {1'b0, block_samples_ff[15:3], 1'b0};
   assign body      = word_in_block_ff - 14'(HEADER_WORDS);
   assign in_body   = (word_in_block_ff >= 14'(HEADER_WORDS)) && ({1'b0, body} < limit);

   // config writes
   always_comb begin
      block_bytes_in   = block_bytes_ff;
      block_samples_in = block_samples_ff;
      skip_blocks_in   = skip_blocks_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BLOCK_BYTES:   block_bytes_in   = csr_wdata;
            CSR_BLOCK_SAMPLES: block_samples_in = csr_wdata;
            CSR_SKIP_BLOCKS:   skip_blocks_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // framing
   always_comb begin
      word_in_block_in  = word_in_block_ff;
      blocks_dropped_in = blocks_dropped_ff;
      group_position_in = group_position_ff;
      first_word_in     = first_word_ff;
      second_word_in    = second_word_ff;
      halted_in         = halted_ff;
      errored           = 1'b0;
      push              = 1'b0;
      push_cmd.kind        = STATUS_SAMPLE;
      push_cmd.first_word  = first_word_ff;
      push_cmd.second_word = second_word_ff;
      push_cmd.third_word  = req_word;
      if (accept) begin
         if (!dropping) begin
            if (word_in_block_ff == 14'd0) begin
               group_position_in = GROUP_FIRST;
               if (req_word != MAGIC_WORD) begin
                  errored       = 1'b1;
                  push          = 1'b1;
                  push_cmd.kind = STATUS_MAGIC;
               end
            end else if (word_in_block_ff == 14'd1) begin
               if (req_word != {16'd0, block_bytes_ff}) begin
                  errored       = 1'b1;
                  push          = 1'b1;
                  push_cmd.kind = STATUS_LENGTH;
               end
            end else if (in_body) begin
               priority case (group_position_ff)
                  GROUP_SECOND: begin
                     second_word_in    = req_word;
                     group_position_in = GROUP_THIRD;
                  end
                  GROUP_THIRD: begin
                     push              = 1'b1;
                     group_position_in = GROUP_FIRST;
                  end
                  default: begin
                     first_word_in     = req_word;
                     group_position_in = GROUP_SECOND;
                  end
               endcase
            end
         end
         if (errored) begin
            halted_in = 1'b1;
         end else if (block_end) begin
            if (dropping) begin
               blocks_dropped_in = blocks_dropped_ff + 16'd1;
            end
            word_in_block_in  = '0;
            group_position_in = GROUP_FIRST;
         end else begin
            word_in_block_in = word_in_block_ff + 14'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff       <= BLOCK_BYTES_RESET;
         block_samples_ff     <= BLOCK_SAMPLES_RESET;
         skip_blocks_ff       <= SKIP_BLOCKS_RESET;
         word_in_block_ff     <= '0;
         blocks_dropped_ff    <= '0;
         group_position_ff    <= GROUP_FIRST;
         first_word_ff        <= '0;
         second_word_ff       <= '0;
         halted_ff            <= 1'b0;
      end else begin
         block_bytes_ff       <= block_bytes_in;
         block_samples_ff     <= block_samples_in;
         skip_blocks_ff       <= skip_blocks_in;
         word_in_block_ff     <= word_in_block_in;
         blocks_dropped_ff    <= blocks_dropped_in;
         group_position_ff    <= group_position_in;
         first_word_ff        <= first_word_in;
         second_word_ff       <= second_word_in;
         halted_ff            <= halted_in;
      end
   end

endmodule

>>> hdl/adcdf_queue.sv
// short command queue between the front end and the sample emitter
`timescale 1ns / 1ps

module adcdf_queue
   import adcdf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type status
);

   cmd_type entry_ff [QUEUE_DEPTH];

   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;

   assign status.full  = count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign head_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_COUNT_WIDTH'(push) - QUEUE_COUNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/adcdf_back.sv
// back end: walks each queued command and drives the result register
`timescale 1ns / 1ps

module adcdf_back
   import adcdf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            head_cmd,
   input  queue_status_type   queue_status,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [11:0] rsp_sample,
   output logic               rsp_last
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic signed [11:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [2:0]         index_ff, index_in;

   logic advance;
   logic load;
   logic is_error;

   assign advance  = ~rsp_valid_ff | rsp_ready;
   assign load     = advance & ~queue_status.empty;
   assign is_error = head_cmd.kind != STATUS_SAMPLE;
   assign pop      = load & (is_error | (index_ff == LAST_SAMPLE_INDEX));

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      index_in      = index_ff;
      if (advance) begin
         rsp_valid_in = ~queue_status.empty;
      end
      if (load) begin
         rsp_status_in = head_cmd.kind;
         if (is_error) begin
            rsp_sample_in = '0;
            rsp_last_in   = 1'b1;
         end else begin
            rsp_sample_in = unpack_sample(head_cmd, index_ff);
            rsp_last_in   = index_ff == LAST_SAMPLE_INDEX;
         end
         index_in = pop ? 3'd0 : index_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         index_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         index_ff     <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

>>> hdl/adcdf_checker.sv
// port-level checks for the block deframer, bound to the top level
`timescale 1ns / 1ps

module adcdf_checker
   import adcdf_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [1:0]          rsp_status,
   input logic signed [11:0]  rsp_sample,
   input logic                rsp_last
);

   // result beat held until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_status))
      else $error("result beat dropped or changed while stalled");

   // error beats carry a zero sample and close the burst
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_SAMPLE |-> rsp_sample == '0 && rsp_last)
      else $error("error beat with sample or without last");

   // nothing follows an error once it is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_status != STATUS_SAMPLE |=> !rsp_valid)
      else $error("result after a halting error");

   // output empty right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind adc_block_deframe_unpack12 adcdf_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_status (rsp_status),
   .rsp_sample (rsp_sample),
   .rsp_last   (rsp_last)
);
